// ----- sv/assert_macros.svh -----
// Shared assertion macros for the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge out of reset.
`define CHK_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never occurs out of reset.
`define CHK_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ----- sv/cdws_pkg.sv -----
`default_nettype none
package cdws_pkg;

  localparam int ENERGY_BINS = 8192;
  localparam int MATRIX_BINS = 1024;

  localparam int EW = 13;  // energy / bin_x width
  localparam int MW = 10;  // matrix bin width
  localparam int TW = 31;  // time tag width
  localparam int WW = 20;  // window length width

  // channels
  localparam logic [15:0] CH_SI_E  = 16'd6;
  localparam logic [15:0] CH_SI_DE = 16'd7;
  localparam logic [15:0] CH_E     = 16'd4;
  localparam logic [15:0] CH_DE    = 16'd5;
  localparam logic [15:0] CH_FP_MAX = 16'd5;

  // spectrum codes
  localparam logic [2:0] SP_SI_E  = 3'd0;
  localparam logic [2:0] SP_SI_DE = 3'd1;
  localparam logic [2:0] SP_SI_2D = 3'd2;
  localparam logic [2:0] SP_E     = 3'd3;
  localparam logic [2:0] SP_DE    = 3'd4;
  localparam logic [2:0] SP_ERROR = 3'd5;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_FP_WINDOW = 3'd1;
  localparam logic [2:0] REG_SI_WINDOW = 3'd2;
  localparam logic [2:0] REG_WRAP      = 3'd3;
  localparam logic [2:0] REG_FP_TRIG   = 3'd4;

  localparam int AW = 5;        // APB byte address width
  localparam int OQ_DEPTH = 4;  // result queue entries
  localparam int OQ_AW = 2;
  localparam int OQ_CW = 3;

  typedef struct packed {
    logic [EW-1:0] energy_threshold;
    logic [WW-1:0] fp_window_ticks;
    logic [WW-1:0] si_window_ticks;
    logic [TW-1:0] timetag_wrap;
    logic [2:0]    fp_trigger_channel;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        channel;
    logic signed [15:0] charge;
    logic [TW-1:0]      time_tag;
    logic               buffer_start;
  } hit_t;

  typedef struct packed {
    logic [2:0]    spectrum_id;
    logic [EW-1:0] bin_x;
    logic [MW-1:0] bin_y;
    logic          last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;  // number of results this cycle, 0..2
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage
`default_nettype wire

// ----- sv/cdws_cfg.sv -----
`default_nettype none
module cdws_cfg (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [cdws_pkg::AW-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output cdws_pkg::cfg_t             cfg
);

  cdws_pkg::cfg_t cfg_r;
  logic [2:0]     idx;
  logic           wr;

  assign idx    = paddr[cdws_pkg::AW-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.energy_threshold   <= 13'd20;
      cfg_r.fp_window_ticks    <= 20'd2500;
      cfg_r.si_window_ticks    <= 20'd2500;
      cfg_r.timetag_wrap       <= 31'h7FFF_FFFF;
      cfg_r.fp_trigger_channel <= 3'd4;
    end else if (wr) begin
      case (idx)
        cdws_pkg::REG_THRESHOLD: cfg_r.energy_threshold   <= pwdata[12:0];
        cdws_pkg::REG_FP_WINDOW: cfg_r.fp_window_ticks    <= pwdata[19:0];
        cdws_pkg::REG_SI_WINDOW: cfg_r.si_window_ticks    <= pwdata[19:0];
        cdws_pkg::REG_WRAP:      cfg_r.timetag_wrap       <= pwdata[30:0];
        cdws_pkg::REG_FP_TRIG:   cfg_r.fp_trigger_channel <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cdws_pkg::REG_THRESHOLD: prdata = {19'd0, cfg_r.energy_threshold};
      cdws_pkg::REG_FP_WINDOW: prdata = {12'd0, cfg_r.fp_window_ticks};
      cdws_pkg::REG_SI_WINDOW: prdata = {12'd0, cfg_r.si_window_ticks};
      cdws_pkg::REG_WRAP:      prdata = {1'b0, cfg_r.timetag_wrap};
      cdws_pkg::REG_FP_TRIG:   prdata = {29'd0, cfg_r.fp_trigger_channel};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/cdws_core.sv -----
`default_nettype none
`include "assert_macros.svh"
module cdws_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cdws_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire cdws_pkg::hit_t  in_data,
  input  wire logic            room,
  output cdws_pkg::push_t      push
);

  // Window test with roll-over of the time tag.
  function automatic logic in_window(input logic valid,
                                     input logic [cdws_pkg::TW-1:0] s,
                                     input logic [cdws_pkg::WW-1:0] w,
                                     input logic [cdws_pkg::TW-1:0] r,
                                     input logic [cdws_pkg::TW-1:0] t);
    logic [31:0]        sw;
    logic signed [32:0] rw;
    logic signed [32:0] swr;
    logic               plain;
    logic               wrapped;
    sw      = {1'b0, s} + {12'd0, w};
    rw      = $signed({2'b00, r}) - $signed({13'd0, w});
    swr     = $signed({1'b0, sw}) - $signed({2'b00, r});
    plain   = (t > s) && ({1'b0, t} < sw);
    wrapped = ($signed({2'b00, s}) > rw) && ($signed({2'b00, t}) < swr);
    return valid && (plain || wrapped);
  endfunction

  function automatic logic [cdws_pkg::MW-1:0] mbin(input logic [cdws_pkg::EW-1:0] e);
    logic [cdws_pkg::EW-4:0] b;
    b = e[cdws_pkg::EW-1:3];
    if (int'(b) > cdws_pkg::MATRIX_BINS - 1) begin
      b = (cdws_pkg::EW-3)'(cdws_pkg::MATRIX_BINS - 1);
    end
    return b[cdws_pkg::MW-1:0];
  endfunction

  logic                    hit_v_r;
  cdws_pkg::hit_t          hit_r;
  logic                    proc;

  logic                    si_valid_r, si_valid_nxt;
  logic [cdws_pkg::TW-1:0] si_start_r, si_start_nxt;
  logic                    si_e_seen_r, si_e_seen_nxt;
  logic                    si_de_seen_r, si_de_seen_nxt;
  logic [cdws_pkg::EW-1:0] si_e_en_r, si_e_en_nxt;
  logic [cdws_pkg::EW-1:0] si_de_en_r, si_de_en_nxt;
  logic                    fp_valid_r, fp_valid_nxt;
  logic [cdws_pkg::TW-1:0] fp_start_r, fp_start_nxt;

  logic signed [13:0]      e_s;
  logic                    drop;
  logic [cdws_pkg::EW-1:0] energy;
  logic                    si_open, fp_open;
  logic                    si_in, fp_in;
  logic                    is_si;

  assign proc     = hit_v_r && room;
  assign in_stall = hit_v_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_v_r <= 1'b0;
    end else if (!in_stall) begin
      hit_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hit_r <= in_data;
    end
  end

  // floor(charge / 4)
  assign e_s    = hit_r.charge[15:2];
  assign drop   = (e_s < $signed({1'b0, cfg.energy_threshold})) ||
                  (int'(e_s) > cdws_pkg::ENERGY_BINS - 1);
  assign energy = e_s[cdws_pkg::EW-1:0];
  assign is_si  = (hit_r.channel == cdws_pkg::CH_SI_E) ||
                  (hit_r.channel == cdws_pkg::CH_SI_DE);
  assign si_open = si_valid_r && !hit_r.buffer_start;
  assign fp_open = fp_valid_r && !hit_r.buffer_start;
  assign si_in = in_window(si_open, si_start_r, cfg.si_window_ticks,
                           cfg.timetag_wrap, hit_r.time_tag);
  assign fp_in = in_window(fp_open, fp_start_r, cfg.fp_window_ticks,
                           cfg.timetag_wrap, hit_r.time_tag);

  always_comb begin
    si_valid_nxt   = si_open;
    si_start_nxt   = si_start_r;
    si_e_seen_nxt  = si_e_seen_r;
    si_de_seen_nxt = si_de_seen_r;
    si_e_en_nxt    = si_e_en_r;
    si_de_en_nxt   = si_de_en_r;
    fp_valid_nxt   = fp_open;
    fp_start_nxt   = fp_start_r;
    push           = '0;
    if (!drop) begin
      if (is_si) begin
        if (si_in) begin
          if (hit_r.channel == cdws_pkg::CH_SI_E && !si_e_seen_r && si_de_seen_r) begin
            si_e_seen_nxt = 1'b1;
            si_e_en_nxt   = energy;
            push.count    = 2'd2;
            push.r0       = '{cdws_pkg::SP_SI_E, energy, '0, 1'b0};
            push.r1       = '{cdws_pkg::SP_SI_2D, {3'd0, mbin(energy)},
                              mbin(si_de_en_r), 1'b1};
          end else if (hit_r.channel == cdws_pkg::CH_SI_DE && !si_de_seen_r &&
                       si_e_seen_r) begin
            si_de_seen_nxt = 1'b1;
            si_de_en_nxt   = energy;
            push.count     = 2'd2;
            push.r0        = '{cdws_pkg::SP_SI_DE, energy, '0, 1'b0};
            push.r1        = '{cdws_pkg::SP_SI_2D, {3'd0, mbin(si_e_en_r)},
                               mbin(energy), 1'b1};
          end
        end else begin
          si_valid_nxt = 1'b1;
          si_start_nxt = hit_r.time_tag;
          push.count   = 2'd1;
          if (hit_r.channel == cdws_pkg::CH_SI_E) begin
            si_e_en_nxt    = energy;
            si_e_seen_nxt  = 1'b1;
            si_de_seen_nxt = 1'b0;
            push.r0        = '{cdws_pkg::SP_SI_E, energy, '0, 1'b1};
          end else begin
            si_de_en_nxt   = energy;
            si_de_seen_nxt = 1'b1;
            si_e_seen_nxt  = 1'b0;
            push.r0        = '{cdws_pkg::SP_SI_DE, energy, '0, 1'b1};
          end
        end
      end else if (hit_r.channel <= cdws_pkg::CH_FP_MAX) begin
        if (!fp_in && hit_r.channel == {13'd0, cfg.fp_trigger_channel}) begin
          fp_valid_nxt = 1'b1;
          fp_start_nxt = hit_r.time_tag;
          if (hit_r.channel == cdws_pkg::CH_E) begin
            push.count = 2'd1;
            push.r0    = '{cdws_pkg::SP_E, energy, '0, 1'b1};
          end else if (hit_r.channel == cdws_pkg::CH_DE) begin
            push.count = 2'd1;
            push.r0    = '{cdws_pkg::SP_DE, energy, '0, 1'b1};
          end
        end
      end else begin
        push.count = 2'd1;
        push.r0    = '{cdws_pkg::SP_ERROR, '0, '0, 1'b1};
      end
    end
    if (!proc) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_valid_r   <= 1'b0;
      si_start_r   <= '0;
      si_e_seen_r  <= 1'b0;
      si_de_seen_r <= 1'b0;
      si_e_en_r    <= '0;
      si_de_en_r   <= '0;
      fp_valid_r   <= 1'b0;
      fp_start_r   <= '0;
    end else if (proc) begin
      si_valid_r   <= si_valid_nxt;
      si_start_r   <= si_start_nxt;
      si_e_seen_r  <= si_e_seen_nxt;
      si_de_seen_r <= si_de_seen_nxt;
      si_e_en_r    <= si_e_en_nxt;
      si_de_en_r   <= si_de_en_nxt;
      fp_valid_r   <= fp_valid_nxt;
      fp_start_r   <= fp_start_nxt;
    end
  end

  `CHK_PROP(a_si_window_has_seen, clk, rst_n,
            si_valid_r |-> (si_e_seen_r || si_de_seen_r),
            "open silicon window with no hit recorded")
  `CHK_PROP(a_pair_order, clk, rst_n,
            (push.count == 2'd2) |-> (!push.r0.last && push.r1.last &&
                                      push.r1.spectrum_id == cdws_pkg::SP_SI_2D),
            "coincidence pair emitted out of order")
  `CHK_PROP(a_hold_hit, clk, rst_n,
            in_stall |=> (hit_v_r && $stable(hit_r)),
            "stalled hit lost or changed")

endmodule
`default_nettype wire

// ----- sv/cdws_outq.sv -----
`default_nettype none
`include "assert_macros.svh"
module cdws_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdws_pkg::push_t   push,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cdws_pkg::result_t      out_data
);

  cdws_pkg::result_t          mem_r [cdws_pkg::OQ_DEPTH];
  logic [cdws_pkg::OQ_AW-1:0] wp_r, rp_r;
  logic [cdws_pkg::OQ_CW-1:0] cnt_r;
  logic                       pop;
  logic [cdws_pkg::OQ_AW-1:0] wp1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rp_r];
  assign pop       = out_valid && !out_stall;
  assign room      = cnt_r <= cdws_pkg::OQ_CW'(cdws_pkg::OQ_DEPTH - 2);
  assign wp1       = wp_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + cdws_pkg::OQ_AW'(push.count);
      rp_r  <= rp_r + cdws_pkg::OQ_AW'(pop);
      cnt_r <= cnt_r + cdws_pkg::OQ_CW'(push.count) - cdws_pkg::OQ_CW'(pop);
    end
  end

  `CHK_PROP(a_push_fits, clk, rst_n,
            (push.count != 2'd0) |->
              (int'(cnt_r) + int'(push.count) <= cdws_pkg::OQ_DEPTH),
            "result queue overflow")
  `CHK_NEVER(a_cnt_range, clk, rst_n, int'(cnt_r) > cdws_pkg::OQ_DEPTH,
             "result queue count out of range")

endmodule
`default_nettype wire

// ----- sv/detector_coincidence_window_sorter_unit.sv -----
`default_nettype none
// Coincidence window sorter: turns timestamped detector hits into histogram
// increment beats. Each hit beat is registered, then handled against the
// silicon and focal-plane window state, and its zero, one or two results
// drop into a four-entry result queue that feeds the out_ port.
// A hit is accepted every cycle while the queue has room for two results;
// the queue gives out one result beat per cycle while out_stall is low, so
// a stream of silicon coincidences (two results each) is held back by the
// result port, other hits run at up to one per cycle. A hit beat passes the
// hit register and the result queue before its first result beat appears.
// Energy is floor(charge/4); hits below energy_threshold are dropped but a
// buffer_start on them still closes both windows. Unknown channels give one
// result with spectrum 5. Window tests allow for roll-over at timetag_wrap.
// Registers sit on the APB port at byte address 4*index: energy_threshold,
// fp_window_ticks, si_window_ticks, timetag_wrap, fp_trigger_channel; write
// them only while the block is idle.
module detector_coincidence_window_sorter_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // hit beats
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire cdws_pkg::hit_t          in_data,
  // result beats
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output cdws_pkg::result_t            out_data,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [cdws_pkg::AW-1:0] paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  cdws_pkg::cfg_t  cfg;
  cdws_pkg::push_t push;
  logic            room;

  // register file
  cdws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // hit register and window logic; advance only when the queue has room
  cdws_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .push     (push)
  );

  // result queue: hold results until the consumer takes them
  cdws_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
